FILE: rtl/lamport_mutex_node_assert.svh
// assertion macros for the lamport mutex node checker
// no dependencies; included by the checker file
`ifndef LAMPORT_MUTEX_NODE_ASSERT_SVH
`define LAMPORT_MUTEX_NODE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LMX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lamport_mutex_node: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define LMX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lamport_mutex_node: next-cycle check failed");

`endif

FILE: rtl/lmx_pkg.sv
// shared types, codes and constants of the lamport mutex node
// no dependencies; imported by every module of the block
package lmx_pkg;

    // field widths fixed by the item formats
    localparam int NODE_W      = 4;
    localparam int OP_W        = 3;
    localparam int KIND_W      = 3;
    localparam int PEER_TIME_W = 32;
    localparam int MSG_TIME_W  = 32;
    localparam int REPLY_W     = 3;
    localparam int ID_CNT_W    = NODE_W + 1;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 4;

    // defaults of the top-level parameters
    localparam int MAX_NODES_DEF = 8;
    localparam int TIME_BITS_DEF = 32;

    // command queue between front and back
    localparam int CMD_FIFO_DEPTH = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MY_NODE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = CFG_IDX_W'(1);

    // reset values of the configuration registers
    localparam logic [NODE_W-1:0] MY_NODE_RST    = NODE_W'(1);
    localparam logic [NODE_W-1:0] NODE_COUNT_RST = NODE_W'(2);

    localparam logic [REPLY_W-1:0] REPLY_MAX = '1;

    // input operation codes
    typedef enum logic [OP_W-1:0] {
        OP_TICK         = 3'd0,
        OP_REQUEST      = 3'd1,
        OP_RELEASE      = 3'd2,
        OP_RECV_REQUEST = 3'd3,
        OP_RECV_REPLY   = 3'd4,
        OP_RECV_RELEASE = 3'd5
    } t_op;

    // result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_STATUS  = 3'd0,
        KIND_REQUEST = 3'd1,
        KIND_REPLY   = 3'd2,
        KIND_RELEASE = 3'd3,
        KIND_ENTER   = 3'd4
    } t_kind;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_REQUEST,
        CMD_RELEASE,
        CMD_RECV_REQUEST,
        CMD_RECV_REPLY,
        CMD_RECV_RELEASE
    } t_cmd;

    typedef struct packed {
        t_cmd                   cmd;
        logic [NODE_W-1:0]      peer;
        logic [PEER_TIME_W-1:0] peer_time;
    } t_cmd_item;

    // request queue control and status
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [NODE_W-1:0] node;
    } t_q_ctrl;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [NODE_W-1:0] head_node;
    } t_q_stat;

    // back-end sequencer
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_CHECK,
        BK_BCAST,
        BK_REPLY,
        BK_FINAL
    } t_back_state;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_BCAST,
        EM_REPLY
    } t_emit;

    // node count clipped to the supported maximum
    function automatic logic [ID_CNT_W-1:0] nodes_eff(
        input logic [NODE_W-1:0] node_count,
        input int                max_nodes
    );
        logic [ID_CNT_W-1:0] res;
        if (int'(node_count) > max_nodes) begin
            res = ID_CNT_W'(max_nodes);
        end else begin
            res = ID_CNT_W'(node_count);
        end
        return res;
    endfunction

endpackage

FILE: rtl/lmx_item_if.sv
// input channel of the lamport mutex node: valid/ready plus item fields
// no dependencies
interface lmx_item_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [3:0]  peer_node;
    logic [31:0] peer_time;

    modport source (output valid, output operation, output peer_node, output peer_time,
                    input ready);
    modport sink   (input valid, input operation, input peer_node, input peer_time,
                    output ready);
endinterface

FILE: rtl/lmx_result_if.sv
// result channel of the lamport mutex node: valid/ready plus result fields
// no dependencies
interface lmx_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  dest_node;
    logic [31:0] msg_time;
    logic        in_section;
    logic        queue_overflow;
    logic        last;

    modport source (output valid, output kind, output dest_node, output msg_time,
                    output in_section, output queue_overflow, output last,
                    input ready);
    modport sink   (input valid, input kind, input dest_node, input msg_time,
                    input in_section, input queue_overflow, input last,
                    output ready);
endinterface

FILE: rtl/lamport_mutex_node.sv
// One node of Lamport distributed mutual exclusion. Items (local tick, request,
// release, and received request, reply or release) enter a two-deep command
// queue; the back end applies one item at a time and sends its results out
// through an output register, at most one result per cycle while the receiver
// is ready. An item passes through take, apply, entry check and a closing step
// that sends the entered-section or status result when there is one; a request
// or release that goes out adds a broadcast walk over the ids from 1 to the
// clipped node_count, skipping its own id, and a received request adds a reply.
// The back end takes no new item until the last one is through. The request
// queue is a sorted register array with one insert or remove per cycle; no
// clearing pass is needed after reset.
// Depends on lmx_pkg, lmx_item_if, lmx_result_if and the lmx_* submodules.
module lamport_mutex_node
    import lmx_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    lmx_item_if.sink              i_item,
    lmx_result_if.source          o_result
);

    logic [NODE_W-1:0]    r_my_node;
    logic [NODE_W-1:0]    r_node_count;
    logic                 push, pop, fifo_full, fifo_empty;
    t_cmd_item            front_cmd, fifo_cmd;
    t_q_ctrl              q_ctrl;
    t_q_stat              q_stat;
    logic [TIME_BITS-1:0] q_time;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_node    <= MY_NODE_RST;
            r_node_count <= NODE_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MY_NODE:    r_my_node    <= NODE_W'(i_cfg_data);
                CFG_NODE_COUNT: r_node_count <= NODE_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    lmx_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .i_my_node    (r_my_node),
        .i_node_count (r_node_count),
        .i_item       (i_item),
        .i_fifo_full  (fifo_full),
        .o_push       (push),
        .o_cmd        (front_cmd)
    );

    lmx_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (fifo_cmd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    lmx_req_queue #(
        .MAX_NODES (MAX_NODES),
        .TIME_BITS (TIME_BITS)
    ) u_req_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (q_ctrl),
        .i_time  (q_time),
        .o_stat  (q_stat)
    );

    lmx_back #(
        .MAX_NODES (MAX_NODES),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_my_node    (r_my_node),
        .i_node_count (r_node_count),
        .i_cmd        (fifo_cmd),
        .i_cmd_empty  (fifo_empty),
        .o_cmd_pop    (pop),
        .o_q_ctrl     (q_ctrl),
        .o_q_time     (q_time),
        .i_q_stat     (q_stat),
        .o_result     (o_result)
    );

endmodule

FILE: rtl/lmx_front.sv
// front end: accepts input items and classifies them into commands
// depends on lmx_pkg and lmx_item_if
module lmx_front
    import lmx_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic [NODE_W-1:0] i_my_node,
    input  logic [NODE_W-1:0] i_node_count,
    lmx_item_if.sink          i_item,
    input  logic              i_fifo_full,
    output logic              o_push,
    output t_cmd_item         o_cmd
);

    logic [ID_CNT_W-1:0] nodes;
    logic                peer_ok;

    // sender must be a known peer other than this node
    assign nodes   = nodes_eff(i_node_count, MAX_NODES);
    assign peer_ok = (i_item.peer_node != '0)
                  && (ID_CNT_W'(i_item.peer_node) <= nodes)
                  && (i_item.peer_node != i_my_node);

    // handshake follows the command queue
    assign i_item.ready = !i_fifo_full;
    assign o_push       = i_item.valid && !i_fifo_full;

    // operation decode
    always_comb begin
        o_cmd.peer      = i_item.peer_node;
        o_cmd.peer_time = i_item.peer_time;
        case (t_op'(i_item.operation))
            OP_TICK:         o_cmd.cmd = CMD_TICK;
            OP_REQUEST:      o_cmd.cmd = CMD_REQUEST;
            OP_RELEASE:      o_cmd.cmd = CMD_RELEASE;
            OP_RECV_REQUEST: o_cmd.cmd = peer_ok ? CMD_RECV_REQUEST : CMD_NOP;
            OP_RECV_REPLY:   o_cmd.cmd = peer_ok ? CMD_RECV_REPLY : CMD_NOP;
            OP_RECV_RELEASE: o_cmd.cmd = peer_ok ? CMD_RECV_RELEASE : CMD_NOP;
            default:         o_cmd.cmd = CMD_NOP;
        endcase
    end

endmodule

FILE: rtl/lmx_cmd_fifo.sv
// short command queue between the front and back ends
// depends on lmx_pkg
module lmx_cmd_fifo
    import lmx_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd_item i_cmd,
    input  logic      i_pop,
    output t_cmd_item o_cmd,
    output logic      o_full,
    output logic      o_empty
);

    localparam int PW = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(CMD_FIFO_DEPTH - 1);

    t_cmd_item     r_mem [CMD_FIFO_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(CMD_FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

FILE: rtl/lmx_req_queue.sv
// request queue sorted by (time, node) with one insert or remove per cycle
// depends on lmx_pkg
module lmx_req_queue
    import lmx_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_q_ctrl              i_ctrl,
    input  logic [TIME_BITS-1:0] i_time,
    output t_q_stat              o_stat
);

    localparam int CW = $clog2(MAX_NODES + 1);

    logic [TIME_BITS-1:0] r_time [MAX_NODES];
    logic [NODE_W-1:0]    r_node [MAX_NODES];
    logic [TIME_BITS-1:0] n_time [MAX_NODES];
    logic [NODE_W-1:0]    n_node [MAX_NODES];
    logic [TIME_BITS-1:0] up_time [MAX_NODES];
    logic [NODE_W-1:0]    up_node [MAX_NODES];
    logic [TIME_BITS-1:0] dn_time [MAX_NODES];
    logic [NODE_W-1:0]    dn_node [MAX_NODES];
    logic [CW-1:0]        r_count, n_count;
    logic [MAX_NODES-1:0] used, le, le_prev, hit, found;

    assign o_stat.full      = (r_count == CW'(MAX_NODES));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.head_node = r_node[0];

    // per-entry compare against the new key and the node to remove
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            used[i] = CW'(i) < r_count;
            le[i]   = used[i] && !((i_time < r_time[i])
                   || ((i_time == r_time[i]) && (i_ctrl.node < r_node[i])));
            hit[i]  = used[i] && (r_node[i] == i_ctrl.node);
        end
        le_prev[0] = 1'b1;
        found[0]   = hit[0];
        for (int i = 1; i < MAX_NODES; i++) begin
            le_prev[i] = le[i-1];
            found[i]   = found[i-1] | hit[i];
        end
    end

    // neighbors for shifting up on insert and down on remove
    always_comb begin
        up_time[0] = i_time;
        up_node[0] = i_ctrl.node;
        for (int i = 1; i < MAX_NODES; i++) begin
            up_time[i] = r_time[i-1];
            up_node[i] = r_node[i-1];
        end
        for (int i = 0; i < MAX_NODES - 1; i++) begin
            dn_time[i] = r_time[i+1];
            dn_node[i] = r_node[i+1];
        end
        dn_time[MAX_NODES-1] = r_time[MAX_NODES-1];
        dn_node[MAX_NODES-1] = r_node[MAX_NODES-1];
    end

    // new contents; a new entry lands behind entries with an equal key
    always_comb begin
        n_count = r_count;
        for (int i = 0; i < MAX_NODES; i++) begin
            n_time[i] = r_time[i];
            n_node[i] = r_node[i];
        end
        if (i_ctrl.ins && !o_stat.full) begin
            n_count = r_count + 1'b1;
            for (int i = 0; i < MAX_NODES; i++) begin
                if (!le[i]) begin
                    n_time[i] = le_prev[i] ? i_time : up_time[i];
                    n_node[i] = le_prev[i] ? i_ctrl.node : up_node[i];
                end
            end
        end else if (i_ctrl.rem && found[MAX_NODES-1]) begin
            n_count = r_count - 1'b1;
            for (int i = 0; i < MAX_NODES; i++) begin
                if (found[i]) begin
                    n_time[i] = dn_time[i];
                    n_node[i] = dn_node[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // entry storage, meaningful only below the fill count
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_NODES; i++) begin
            r_time[i] <= n_time[i];
            r_node[i] <= n_node[i];
        end
    end

endmodule

FILE: rtl/lmx_back.sv
// back end: applies commands to the clock, queue and reply state and emits results
// depends on lmx_pkg, lmx_result_if; drives lmx_req_queue through its ports
module lmx_back
    import lmx_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [NODE_W-1:0]    i_my_node,
    input  logic [NODE_W-1:0]    i_node_count,
    input  t_cmd_item            i_cmd,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    output t_q_ctrl              o_q_ctrl,
    output logic [TIME_BITS-1:0] o_q_time,
    input  t_q_stat              i_q_stat,
    lmx_result_if.source         o_result
);

    t_back_state          r_state, n_state;
    t_cmd_item            r_cmd, n_cmd;
    logic [TIME_BITS-1:0] r_clock, n_clock;
    logic [REPLY_W-1:0]   r_reply, n_reply;
    logic                 r_waiting, n_waiting;
    logic                 r_holding, n_holding;
    logic                 r_overflow, n_overflow;
    logic                 r_enter, n_enter;
    logic                 r_any, n_any;
    t_emit                r_emit, n_emit;
    t_kind                r_bkind, n_bkind;
    logic [ID_CNT_W-1:0]  r_j, n_j;

    // output register
    logic                  r_out_valid, n_out_valid;
    t_kind                 r_out_kind, n_out_kind;
    logic [NODE_W-1:0]     r_out_dest, n_out_dest;
    logic [MSG_TIME_W-1:0] r_out_time, n_out_time;
    logic                  r_out_sect, n_out_sect;
    logic                  r_out_ovf, n_out_ovf;
    logic                  r_out_last, n_out_last;

    logic [ID_CNT_W-1:0]  nodes, needed, my_id, j1, j2;
    logic [TIME_BITS-1:0] ptime, tmax, clk_rx;
    logic                 can_emit, no_more;
    logic                 emit, e_last;
    t_kind                e_kind;
    logic [NODE_W-1:0]    e_dest;

    assign nodes  = nodes_eff(i_node_count, MAX_NODES);
    assign needed = (nodes >= ID_CNT_W'(2)) ? nodes - 1'b1 : '0;
    assign my_id  = ID_CNT_W'(i_my_node);

    // receive clock: max of both clocks plus one, saturating
    assign ptime  = TIME_BITS'(r_cmd.peer_time);
    assign tmax   = (r_clock > ptime) ? r_clock : ptime;
    assign clk_rx = (&tmax) ? tmax : tmax + 1'b1;

    // broadcast walk: is there a destination after j
    assign j1      = r_j + 1'b1;
    assign j2      = r_j + ID_CNT_W'(2);
    assign no_more = (j1 > nodes) || ((j1 == my_id) && (j2 > nodes));

    assign can_emit = !r_out_valid || o_result.ready;

    assign o_result.valid          = r_out_valid;
    assign o_result.kind           = r_out_kind;
    assign o_result.dest_node      = r_out_dest;
    assign o_result.msg_time       = r_out_time;
    assign o_result.in_section     = r_out_sect;
    assign o_result.queue_overflow = r_out_ovf;
    assign o_result.last           = r_out_last;

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_clock     = r_clock;
        n_reply     = r_reply;
        n_waiting   = r_waiting;
        n_holding   = r_holding;
        n_overflow  = r_overflow;
        n_enter     = r_enter;
        n_any       = r_any;
        n_emit      = r_emit;
        n_bkind     = r_bkind;
        n_j         = r_j;
        n_out_valid = r_out_valid && !o_result.ready;
        n_out_kind  = r_out_kind;
        n_out_dest  = r_out_dest;
        n_out_time  = r_out_time;
        n_out_sect  = r_out_sect;
        n_out_ovf   = r_out_ovf;
        n_out_last  = r_out_last;
        o_cmd_pop   = 1'b0;
        o_q_ctrl    = '0;
        o_q_time    = r_clock;
        emit        = 1'b0;
        e_kind      = KIND_STATUS;
        e_dest      = '0;
        e_last      = 1'b0;

        case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_overflow = 1'b0;
                n_any      = 1'b0;
                n_j        = ID_CNT_W'(1);
                n_emit     = EM_NONE;
                n_bkind    = KIND_REQUEST;
                n_state    = BK_CHECK;
                case (r_cmd.cmd)
                    CMD_TICK: begin
                        n_clock = (&r_clock) ? r_clock : r_clock + 1'b1;
                    end
                    CMD_REQUEST: begin
                        if (!r_waiting && !r_holding) begin
                            n_reply       = '0;
                            n_waiting     = 1'b1;
                            o_q_ctrl.ins  = 1'b1;
                            o_q_ctrl.node = i_my_node;
                            o_q_time      = r_clock;
                            n_overflow    = i_q_stat.full;
                            n_emit        = EM_BCAST;
                        end
                    end
                    CMD_RELEASE: begin
                        if (r_holding) begin
                            n_holding     = 1'b0;
                            o_q_ctrl.rem  = 1'b1;
                            o_q_ctrl.node = i_my_node;
                            n_emit        = EM_BCAST;
                            n_bkind       = KIND_RELEASE;
                        end
                    end
                    CMD_RECV_REQUEST: begin
                        n_clock       = clk_rx;
                        o_q_ctrl.ins  = 1'b1;
                        o_q_ctrl.node = r_cmd.peer;
                        o_q_time      = ptime;
                        n_overflow    = i_q_stat.full;
                        n_emit        = EM_REPLY;
                    end
                    CMD_RECV_REPLY: begin
                        n_clock = clk_rx;
                        if (r_waiting && (r_reply != REPLY_MAX)) begin
                            n_reply = r_reply + 1'b1;
                        end
                    end
                    CMD_RECV_RELEASE: begin
                        o_q_ctrl.rem  = 1'b1;
                        o_q_ctrl.node = r_cmd.peer;
                    end
                    default: begin
                    end
                endcase
            end
            BK_CHECK: begin
                // enter once all replies are in and our entry heads the queue
                n_enter = r_waiting && (ID_CNT_W'(r_reply) >= needed)
                       && !i_q_stat.empty && (i_q_stat.head_node == i_my_node);
                if (n_enter) begin
                    n_waiting = 1'b0;
                    n_holding = 1'b1;
                end
                case (r_emit)
                    EM_BCAST: n_state = BK_BCAST;
                    EM_REPLY: n_state = BK_REPLY;
                    default:  n_state = BK_FINAL;
                endcase
            end
            BK_BCAST: begin
                if (r_j > nodes) begin
                    n_state = BK_FINAL;
                end else if (r_j == my_id) begin
                    n_j = j1;
                end else if (can_emit) begin
                    emit   = 1'b1;
                    e_kind = r_bkind;
                    e_dest = NODE_W'(r_j);
                    e_last = no_more && !r_enter;
                    n_any  = 1'b1;
                    n_j    = j1;
                end
            end
            BK_REPLY: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    e_kind  = KIND_REPLY;
                    e_dest  = r_cmd.peer;
                    e_last  = !r_enter;
                    n_any   = 1'b1;
                    n_state = BK_FINAL;
                end
            end
            BK_FINAL: begin
                if (r_enter || !r_any) begin
                    if (can_emit) begin
                        emit    = 1'b1;
                        e_kind  = r_enter ? KIND_ENTER : KIND_STATUS;
                        e_last  = 1'b1;
                        n_state = BK_IDLE;
                    end
                end else begin
                    n_state = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        // load the output register
        if (emit) begin
            n_out_valid = 1'b1;
            n_out_kind  = e_kind;
            n_out_dest  = e_dest;
            n_out_time  = MSG_TIME_W'(r_clock);
            n_out_sect  = r_holding;
            n_out_ovf   = r_overflow;
            n_out_last  = e_last;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_clock     <= '0;
            r_reply     <= '0;
            r_waiting   <= 1'b0;
            r_holding   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clock     <= n_clock;
            r_reply     <= n_reply;
            r_waiting   <= n_waiting;
            r_holding   <= n_holding;
            r_out_valid <= n_out_valid;
        end
    end

    // per-item working registers and result payload
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_overflow <= n_overflow;
        r_enter    <= n_enter;
        r_any      <= n_any;
        r_emit     <= n_emit;
        r_bkind    <= n_bkind;
        r_j        <= n_j;
        r_out_kind <= n_out_kind;
        r_out_dest <= n_out_dest;
        r_out_time <= n_out_time;
        r_out_sect <= n_out_sect;
        r_out_ovf  <= n_out_ovf;
        r_out_last <= n_out_last;
    end

endmodule

FILE: rtl/lmx_checker.sv
// port-level checks of the lamport mutex node, bound to the top level
// depends on lmx_pkg and lamport_mutex_node_assert.svh
`include "lamport_mutex_node_assert.svh"

module lmx_checker
    import lmx_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [2:0]  i_kind,
    input logic [3:0]  i_dest_node,
    input logic [31:0] i_msg_time,
    input logic        i_in_section,
    input logic        i_last
);

    // status and entered-section results go to nobody
    `LMX_ASSERT_NOW(a_local_dest, i_clk, i_rst_n, i_valid && ((i_kind == KIND_STATUS) || (i_kind == KIND_ENTER)), i_dest_node == '0)

    // entering closes the item and shows the section held
    `LMX_ASSERT_NOW(a_enter_holds, i_clk, i_rst_n, i_valid && (i_kind == KIND_ENTER), i_in_section && i_last)

    // a release broadcast is only sent after leaving the section
    `LMX_ASSERT_NOW(a_release_free, i_clk, i_rst_n, i_valid && (i_kind == KIND_RELEASE), !i_in_section)

    // a stalled result holds
    `LMX_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_kind) && $stable(i_dest_node) && $stable(i_msg_time) && $stable(i_last))

endmodule

bind lamport_mutex_node lmx_checker u_lmx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_result.valid),
    .i_ready      (o_result.ready),
    .i_kind       (o_result.kind),
    .i_dest_node  (o_result.dest_node),
    .i_msg_time   (o_result.msg_time),
    .i_in_section (o_result.in_section),
    .i_last       (o_result.last)
);
